[hdl/eap_pkg.sv]
// Shared constants, types and helpers for the EEPROM access planner.
package eap_pkg;

  localparam int CACHE_BYTES = 64;
  // The page size must be a power of two; page offsets are taken as a mask.
  localparam int PAGE_BYTES  = 16;

  localparam int ALU_W   = 12;
  localparam int WLEN_W  = $clog2(CACHE_BYTES + 1);
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = $clog2(PAGE_BYTES + 1);
  localparam int MAX_SPAN = 256;

  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;
  localparam logic [1:0] KIND_WRITE  = 2'd3;

  localparam logic [1:0] REG_DEVICE_CODE = 2'd0;
  localparam logic [1:0] REG_DEVICE_END  = 2'd1;

  localparam logic [7:0]  DEVICE_CODE_RESET = 8'hA0;
  localparam logic [11:0] DEVICE_END_RESET  = 12'd2048;

  // Result of the shared subtractor.
  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
    logic             zero;
  } alu_res_t;

  // Device select byte: block bits from address bits 10..8, R/W bit clear.
  function automatic logic [7:0] select_for(input logic [7:0] code,
                                            input logic [2:0] block);
    select_for = (code | {4'b0000, block, 1'b0}) & 8'hFE;
  endfunction

endpackage

[hdl/eap_alu.sv]
// Shared subtract and compare unit of the access planner.
module eap_alu
  import eap_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output alu_res_t         res
);

  logic [ALU_W:0] full;

  assign full       = {1'b0, a} - {1'b0, b};
  assign res.diff   = full[ALU_W-1:0];
  assign res.borrow = full[ALU_W];
  assign res.zero   = (full == '0);

endmodule

[hdl/eeprom_access_planner_core.sv]
// Top level of the EEPROM access planner: sequencer, window state and output register.
//
// Each request word is planned by a small sequencer around one shared 12-bit
// subtractor, and the block takes no new request while one is in progress.
// After the accept, a read compares the start against the window start, then
// the span end against the window end, and a cache fill adds a step that clips
// against device_end. After the accept, a write handles one page segment at a
// time, each segment using the subtractor once to clip the
// page remainder against the bytes left; a write with an empty span still
// passes once through the segment state. Results go through an output
// register, so a new request is accepted while the last result still waits;
// the sequencer holds when it has a result to load and that register is full and not being taken.
module eeprom_access_planner_core
  import eap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [10:0] start_address,
  input  logic [8:0]  span_length,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  access_kind,
  output logic [7:0]  select_byte,
  output logic [7:0]  word_byte,
  output logic [8:0]  byte_count,
  output logic [5:0]  cache_offset,
  output logic        last
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RD_LO   = 5'b00010,
    S_RD_HI   = 5'b00100,
    S_RD_FILL = 5'b01000,
    S_WR_SEG  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [7:0]        device_code;
  logic [11:0]       device_end;

  logic              window_valid;
  logic [10:0]       window_start;
  logic [WLEN_W-1:0] window_length;
  logic [11:0]       segment_address;
  logic [8:0]        bytes_remaining;

  logic [10:0]       req_start;
  logic [8:0]        req_len;
  logic              below_start;
  logic [5:0]        hit_offset;

  logic [ALU_W-1:0]  alu_a, alu_b;
  alu_res_t          alu_res;
  logic              slot_free;
  logic [PAGE_W-1:0] page_n;
  logic [8:0]        seg_n;
  logic [8:0]        rem_next;
  logic [WLEN_W-1:0] fill;
  logic              is_hit;
  logic              is_long;
  logic              load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign page_n = PAGE_W'(PAGE_BYTES) - PAGE_W'(segment_address[PAGE_BITS-1:0]);

  // Operand selection for the shared subtractor.
  always_comb begin
    case (state)
      S_RD_LO: begin
        alu_a = {1'b0, req_start};
        alu_b = {1'b0, window_start};
      end
      S_RD_HI: begin
        alu_a = {1'b0, window_start} + ALU_W'(window_length);
        alu_b = {1'b0, req_start} + ALU_W'(req_len);
      end
      S_RD_FILL: begin
        alu_a = device_end;
        alu_b = {1'b0, req_start};
      end
      S_WR_SEG: begin
        alu_a = ALU_W'(bytes_remaining);
        alu_b = ALU_W'(page_n);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  eap_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign is_hit  = window_valid && !below_start && !alu_res.borrow;
  assign is_long = (req_len >= 9'(CACHE_BYTES));

  always_comb begin
    if (alu_res.borrow || alu_res.zero) begin
      fill = '0;
    end else if (alu_res.diff >= ALU_W'(CACHE_BYTES)) begin
      fill = WLEN_W'(CACHE_BYTES);
    end else begin
      fill = alu_res.diff[WLEN_W-1:0];
    end
  end

  // A segment ends at the page border or at the end of the span.
  always_comb begin
    if (alu_res.borrow) begin
      seg_n    = bytes_remaining;
      rem_next = '0;
    end else begin
      seg_n    = 9'(page_n);
      rem_next = alu_res.diff[8:0];
    end
  end

  // The output register takes a new word in these cases.
  always_comb begin
    case (state)
      S_RD_HI:   load_out = (is_hit || is_long) && slot_free;
      S_RD_FILL: load_out = slot_free;
      S_WR_SEG:  load_out = (bytes_remaining != '0) && slot_free;
      default:   load_out = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = operation ? S_WR_SEG : S_RD_LO;
        end
      end
      S_RD_LO: state_next = S_RD_HI;
      S_RD_HI: begin
        if (!is_hit && !is_long) begin
          state_next = S_RD_FILL;
        end else if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_RD_FILL: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_WR_SEG: begin
        if (bytes_remaining == '0) begin
          state_next = S_IDLE;
        end else if (slot_free && rem_next == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      device_code   <= DEVICE_CODE_RESET;
      device_end    <= DEVICE_END_RESET;
      window_valid  <= 1'b0;
      window_start  <= '0;
      window_length <= '0;
      segment_address <= '0;
      bytes_remaining <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          REG_DEVICE_CODE: device_code <= cfg_data[7:0];
          REG_DEVICE_END:  device_end  <= cfg_data;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_start <= start_address;
            req_len   <= span_length;
            if (operation) begin
              window_valid    <= 1'b0;
              window_start    <= '0;
              window_length   <= '0;
              segment_address <= {1'b0, start_address};
              bytes_remaining <= (span_length > 9'(MAX_SPAN)) ? 9'(MAX_SPAN) : span_length;
            end
          end
        end
        S_RD_LO: begin
          below_start <= alu_res.borrow;
          hit_offset  <= alu_res.diff[5:0];
        end
        S_RD_HI: begin
          if ((is_hit || is_long) && slot_free) begin
            last      <= 1'b1;
            byte_count <= req_len;
            if (is_hit) begin
              access_kind  <= KIND_HIT;
              select_byte  <= '0;
              word_byte    <= '0;
              cache_offset <= hit_offset;
            end else begin
              access_kind   <= KIND_DIRECT;
              select_byte   <= select_for(device_code, req_start[10:8]);
              word_byte     <= req_start[7:0];
              cache_offset  <= '0;
              window_valid  <= 1'b1;
              window_start  <= req_start;
              window_length <= WLEN_W'(CACHE_BYTES);
            end
          end
        end
        S_RD_FILL: begin
          if (slot_free) begin
            last          <= 1'b1;
            access_kind   <= KIND_FILL;
            select_byte   <= select_for(device_code, req_start[10:8]);
            word_byte     <= req_start[7:0];
            byte_count    <= 9'(fill);
            cache_offset  <= '0;
            window_start  <= req_start;
            window_length <= fill;
            window_valid  <= (fill != '0);
          end
        end
        S_WR_SEG: begin
          if (bytes_remaining != '0 && slot_free) begin
            last            <= (rem_next == '0);
            access_kind     <= KIND_WRITE;
            select_byte     <= select_for(device_code, segment_address[10:8]);
            word_byte       <= segment_address[7:0];
            byte_count      <= seg_n;
            cache_offset    <= '0;
            bytes_remaining <= rem_next;
            segment_address <= segment_address + 12'(seg_n);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the EEPROM access planner core.
`timescale 1ns / 100ps

module tb
  import eap_pkg::*;
();

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Indexes past the two defined registers; writes to them must change nothing.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 72;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] select;
    logic [7:0] word;
    logic [8:0] count;
    logic [5:0] offset;
    logic       last;
  } access_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_t;

  // A request row carries start address and span length in arg_a and arg_b;
  // a register row carries write data and register index in the same places.
  typedef struct packed {
    row_t        row;
    logic        op;
    logic [11:0] arg_a;
    logic [8:0]  arg_b;
    logic        typed;
    access_t     want;
  } step_t;

  localparam access_t UNCHECKED = '0;
  localparam int DIRECTED_ROWS = 32;

  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_REQ, OP_READ, 12'd0, 9'd1, 1'b1, '{KIND_FILL, 8'hA0, 8'h00, 9'd64, 6'd0, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd5, 9'd10, 1'b1, '{KIND_HIT, 8'h00, 8'h00, 9'd10, 6'd5, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd0, 9'd64, 1'b1, '{KIND_HIT, 8'h00, 8'h00, 9'd64, 6'd0, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd63, 9'd0, 1'b1, '{KIND_HIT, 8'h00, 8'h00, 9'd0, 6'd63, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd64, 9'd0, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd60, 9'd8, 1'b1, '{KIND_FILL, 8'hA0, 8'h3C, 9'd64, 6'd0, 1'b1}},
    '{ROW_REQ, OP_WRITE, 12'd2040, 9'd256, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd60, 9'd8, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_WRITE, 12'd100, 9'd0, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd60, 9'd8, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd2047, 9'd511, 1'b1,
      '{KIND_DIRECT, 8'hAE, 8'hFF, 9'd511, 6'd0, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd2047, 9'd1, 1'b1, '{KIND_HIT, 8'h00, 8'h00, 9'd1, 6'd0, 1'b1}},
    '{ROW_REQ, OP_WRITE, 12'd5, 9'd511, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_WRITE, 12'd2047, 9'd1, 1'b1,
      '{KIND_WRITE, 8'hAE, 8'hFF, 9'd1, 6'd0, 1'b1}},
    '{ROW_REQ, OP_WRITE, 12'd0, 9'd16, 1'b1, '{KIND_WRITE, 8'hA0, 8'h00, 9'd16, 6'd0, 1'b1}},
    '{ROW_REQ, OP_WRITE, 12'd15, 9'd2, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd1000, 9'd63, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd1000, 9'd256, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'h555, 9'h0AA, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_WRITE, 12'h2AA, 9'h155, 1'b0, UNCHECKED},
    '{ROW_CFG, OP_READ, 12'd1, 9'(REG_DEVICE_END), 1'b0, UNCHECKED},
    '{ROW_CFG, OP_READ, 12'hFFF, 9'(REG_DEVICE_CODE), 1'b0, UNCHECKED},
    '{ROW_CFG, OP_READ, 12'hABC, 9'(REG_SPARE_A), 1'b0, UNCHECKED},
    '{ROW_CFG, OP_READ, 12'h543, 9'(REG_SPARE_B), 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd0, 9'd5, 1'b1, '{KIND_FILL, 8'hFE, 8'h00, 9'd1, 6'd0, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd1, 9'd0, 1'b1, '{KIND_HIT, 8'h00, 8'h00, 9'd0, 6'd1, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd5, 9'd3, 1'b1, '{KIND_FILL, 8'hFE, 8'h05, 9'd0, 6'd0, 1'b1}},
    '{ROW_REQ, OP_READ, 12'd5, 9'd0, 1'b1, '{KIND_FILL, 8'hFE, 8'h05, 9'd0, 6'd0, 1'b1}},
    '{ROW_CFG, OP_READ, 12'd4095, 9'(REG_DEVICE_END), 1'b0, UNCHECKED},
    '{ROW_CFG, OP_READ, 12'd0, 9'(REG_DEVICE_CODE), 1'b0, UNCHECKED},
    '{ROW_REQ, OP_READ, 12'd2040, 9'd10, 1'b0, UNCHECKED},
    '{ROW_REQ, OP_WRITE, 12'd2047, 9'd256, 1'b0, UNCHECKED}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [10:0] start_address = '0;
  logic [8:0]  span_length = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  access_kind;
  logic [7:0]  select_byte;
  logic [7:0]  word_byte;
  logic [8:0]  byte_count;
  logic [5:0]  cache_offset;
  logic        last;

  // Predictor state: the cached window and the two registers.
  bit          win_valid;
  int          win_start;
  int          win_len;
  logic [7:0]  dev_code;
  logic [11:0] dev_end;

  access_t     planned_accesses[$];
  access_t     due_access;

  int fail_count = 0;
  int requests_sent = 0;
  int accesses_checked = 0;
  int register_writes = 0;

  bit sender_burst = 1'b0;
  bit receiver_burst = 1'b0;
  int pressure_req = 0;
  int pressure_done = 0;
  int stall_left = 0;

  eeprom_access_planner_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .start_address(start_address),
    .span_length  (span_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .access_kind  (access_kind),
    .select_byte  (select_byte),
    .word_byte    (word_byte),
    .byte_count   (byte_count),
    .cache_offset (cache_offset),
    .last         (last)
  );

  always #10 clk = ~clk;

  function automatic int draw_idle(input bit burst);
    if (burst || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] block_select(input logic [11:0] addr);
    return (dev_code | {4'b0000, addr[10:8], 1'b0}) & 8'hFE;
  endfunction

  // Works out the accesses a request causes and queues them in order.
  function automatic void plan_request(input logic op, input logic [10:0] start,
                                       input logic [8:0] len);
    int          first;
    int          span;
    int          fill;
    int          chunk;
    int          left;
    logic [11:0] seg;
    access_t     acc;
    first = int'(start);
    span = int'(len);
    if (op == OP_READ) begin
      if (win_valid && first >= win_start && win_start + win_len >= first + span) begin
        acc = '{KIND_HIT, 8'h00, 8'h00, len, 6'(first - win_start), 1'b1};
      end else if (span >= CACHE_BYTES) begin
        acc = '{KIND_DIRECT, block_select({1'b0, start}), start[7:0], len, 6'd0, 1'b1};
        win_valid = 1'b1;
        win_start = first;
        win_len = CACHE_BYTES;
      end else begin
        fill = 0;
        if (first < int'(dev_end)) begin
          fill = int'(dev_end) - first;
          if (fill > CACHE_BYTES) fill = CACHE_BYTES;
        end
        acc = '{KIND_FILL, block_select({1'b0, start}), start[7:0], 9'(fill), 6'd0, 1'b1};
        win_start = first;
        win_len = fill;
        win_valid = (fill != 0);
      end
      planned_accesses.push_back(acc);
    end else begin
      win_valid = 1'b0;
      win_start = 0;
      win_len = 0;
      left = (span > MAX_SPAN) ? MAX_SPAN : span;
      seg = {1'b0, start};
      while (left != 0) begin
        chunk = PAGE_BYTES - (int'(seg) % PAGE_BYTES);
        if (chunk > left) chunk = left;
        left -= chunk;
        acc = '{KIND_WRITE, block_select(seg), seg[7:0], 9'(chunk), 6'd0, left == 0};
        planned_accesses.push_back(acc);
        seg = seg + 12'(chunk);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic issue_request(input logic op, input logic [10:0] start,
                               input logic [8:0] len, input logic typed,
                               input access_t want);
    int gap;
    gap = draw_idle(sender_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    start_address <= start;
    span_length <= len;
    do @(posedge clk); while (!in_ready);
    plan_request(op, start, len);
    // Rows with a hand-written result replace the predicted one.
    if (typed) begin
      void'(planned_accesses.pop_back());
      planned_accesses.push_back(want);
    end
    requests_sent++;
  endtask

  // Drops valid, lets every expected result drain, then waits a little longer
  // since a zero-length write leaves the block busy with nothing queued.
  task automatic wait_idle(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (planned_accesses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [11:0] data);
    wait_idle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_DEVICE_CODE) begin
      dev_code = data[7:0];
    end else if (index == REG_DEVICE_END) begin
      dev_end = data;
    end
    register_writes++;
  endtask

  // Result side: checks each accepted word and draws its own stall after it.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (planned_accesses.size() == 0) begin
          $error("access with none expected: kind %0d count %0d", access_kind, byte_count);
          fail_count++;
        end else begin
          due_access = planned_accesses.pop_front();
          check_field("access_kind", due_access.kind, access_kind);
          check_field("select_byte", due_access.select, select_byte);
          check_field("word_byte", due_access.word, word_byte);
          check_field("byte_count", due_access.count, byte_count);
          check_field("cache_offset", due_access.offset, cache_offset);
          check_field("last", due_access.last, last);
        end
        accesses_checked++;
        stall_left = draw_idle(receiver_burst);
      end
      if (pressure_done != pressure_req) begin
        pressure_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int          phase;
    int          n;
    int          pick;
    int          off;
    logic        op;
    logic [10:0] start;
    logic [8:0]  len;

    win_valid = 1'b0;
    win_start = 0;
    win_len = 0;
    dev_code = DEVICE_CODE_RESET;
    dev_end = DEVICE_END_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      if (DIRECTED[n].row == ROW_CFG) begin
        write_register(DIRECTED[n].arg_b[1:0], DIRECTED[n].arg_a);
      end else begin
        issue_request(DIRECTED[n].op, DIRECTED[n].arg_a[10:0], DIRECTED[n].arg_b,
                      DIRECTED[n].typed, DIRECTED[n].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      write_register(REG_DEVICE_CODE, 12'($urandom));
      case (phase)
        0, 3: write_register(REG_DEVICE_END, DEVICE_END_RESET);
        1: write_register(REG_DEVICE_END, 12'd1);
        4: write_register(REG_DEVICE_END, 12'($urandom));
        default: write_register(REG_DEVICE_END, 12'($urandom_range(1, 2048)));
      endcase
      if (phase == 5) write_register(REG_SPARE_A + 2'($urandom_range(0, 1)), 12'($urandom));
      sender_burst = (phase == 2 || phase == 3);
      receiver_burst = (phase == 2);
      // The receiver holds off while words keep coming, so the block backs up.
      if (phase == 3) pressure_req++;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 && win_valid) begin
          op = OP_READ;
          off = $urandom_range(0, win_len);
          start = 11'(win_start + off);
          len = 9'($urandom_range(0, win_len - off));
        end else if (pick < 60) begin
          op = OP_READ;
          start = 11'($urandom);
          len = 9'($urandom_range(0, CACHE_BYTES - 1));
        end else if (pick < 70) begin
          op = OP_READ;
          start = 11'($urandom);
          len = 9'($urandom_range(CACHE_BYTES, 511));
        end else if (pick < 95) begin
          op = OP_WRITE;
          start = 11'($urandom);
          len = ($urandom_range(0, 6) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40));
        end else begin
          op = 1'($urandom);
          start = 11'($urandom);
          len = 9'($urandom);
        end
        issue_request(op, start, len, 1'b0, UNCHECKED);
      end
    end

    wait_idle(40);
    if (planned_accesses.size() != 0) begin
      $error("%0d expected accesses never arrived", planned_accesses.size());
      fail_count++;
    end
    $display("Summary: %0d requests (reads, hits, fills, page writes) planned,", requests_sent);
    $display("  %0d accesses checked over %0d register writes.", accesses_checked,
             register_writes);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
